// File: rtl/lnr_pkg.sv
// Shared types and constants for the line rasterizer.
// Holds the request and response beat structs and the octant class codes.
// No dependencies.
package lnr_pkg;

   localparam int COORD_BITS = 12;
   localparam int SCREEN_W   = 240;
   localparam int SCREEN_H   = 320;
   localparam int COLOR_BITS = 16;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef enum logic [2:0] {
      OCT_VERT         = 3'd0,
      OCT_HORIZ        = 3'd1,
      OCT_SHALLOW_UP   = 3'd2,
      OCT_STEEP_UP     = 3'd3,
      OCT_SHALLOW_DOWN = 3'd4,
      OCT_STEEP_DOWN   = 3'd5
   } octant_type;

   typedef struct packed {
      logic                          kind;
      logic signed [COORD_BITS-1:0]  start_x;
      logic signed [COORD_BITS-1:0]  start_y;
      logic signed [COORD_BITS-1:0]  end_x;
      logic signed [COORD_BITS-1:0]  end_y;
      logic        [COLOR_BITS-1:0]  pixel_color;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  pixel_x;
      logic signed [COORD_BITS-1:0]  pixel_y;
      logic        [COLOR_BITS-1:0]  color_out;
      logic                          on_screen;
      logic                          last;
   } rsp_type;

endpackage

// File: rtl/line_rasterizer.sv
// Bresenham line pixel generator, top level.
// Depends on lnr_pkg for beat structs, octant codes and screen size.
//
//   channel | direction | beat      | meaning
//   req     | in        | req_type  | load a line (kind 0) or ask for a pixel (kind 1)
//   rsp     | out       | rsp_type  | one pixel with on-screen flag and last marker
//
// One request beat per cycle; a step beat's pixel appears in the output register
// the cycle after acceptance. The line state and the response register set the rate.
// req_ready drops only while a pixel waits in the output register and rsp_ready is low.
// Synchronous reset clears the active flag and the output valid.
module line_rasterizer
   import lnr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   logic        [DELTA_BITS-1:0] delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic signed [ERR_BITS-1:0]   step_error_ff, step_error_in;
   octant_type                   octant_ff, octant_in;
   logic        [COLOR_BITS-1:0] color_ff, color_in;
   logic                         active_ff, active_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   // load setup
   logic                         swap_ends;
   logic signed [COORD_BITS-1:0] first_x, first_y, second_x, second_y;
   logic signed [DELTA_BITS-1:0] ld_dx, ld_dy;
   logic        [DELTA_BITS-1:0] ld_dy_abs;
   octant_type                   ld_octant;

   // step datapath
   logic signed [ERR_BITS:0]     dx_w, dy_w, err_w;
   logic signed [ERR_BITS:0]     err_add_dx, err_add_dy, err_sub_dx, err_sub_dy;
   logic signed [ERR_BITS+1:0]   twice_add_dx, twice_add_dy, twice_sub_dx, twice_sub_dy;
   logic signed [ERR_BITS+1:0]   dx_2w, dy_2w;
   logic                         x_at_stop, y_at_stop, fin;
   logic                         accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (req_data.start_x == req_data.end_x) begin
         swap_ends = req_data.start_y > req_data.end_y;
      end else begin
         swap_ends = req_data.start_x > req_data.end_x;
      end
      first_x  = swap_ends ? req_data.end_x   : req_data.start_x;
      first_y  = swap_ends ? req_data.end_y   : req_data.start_y;
      second_x = swap_ends ? req_data.start_x : req_data.end_x;
      second_y = swap_ends ? req_data.start_y : req_data.end_y;
      ld_dx     = DELTA_BITS'(second_x) - DELTA_BITS'(first_x);
      ld_dy     = DELTA_BITS'(second_y) - DELTA_BITS'(first_y);
      ld_dy_abs = ld_dy[DELTA_BITS-1] ? DELTA_BITS'(-ld_dy) : DELTA_BITS'(ld_dy);
      if (first_x == second_x) begin
         ld_octant = OCT_VERT;
      end else if (first_y == second_y) begin
         ld_octant = OCT_HORIZ;
      end else if (!ld_dy[DELTA_BITS-1]) begin
         ld_octant = (ld_dy_abs < ld_dx) ? OCT_SHALLOW_UP : OCT_STEEP_UP;
      end else begin
         ld_octant = (ld_dy_abs < ld_dx) ? OCT_SHALLOW_DOWN : OCT_STEEP_DOWN;
      end
   end

   always_comb begin
      dx_w  = $signed({2'b00, delta_x_ff});
      dy_w  = $signed({2'b00, delta_y_ff});
      err_w = (ERR_BITS+1)'(step_error_ff);
      err_add_dx = err_w + dx_w;
      err_add_dy = err_w + dy_w;
      err_sub_dx = err_w - dx_w;
      err_sub_dy = err_w - dy_w;
      twice_add_dx = $signed({err_add_dx, 1'b0});
      twice_add_dy = $signed({err_add_dy, 1'b0});
      twice_sub_dx = $signed({err_sub_dx, 1'b0});
      twice_sub_dy = $signed({err_sub_dy, 1'b0});
      dx_2w = (ERR_BITS+2)'(dx_w);
      dy_2w = (ERR_BITS+2)'(dy_w);
      x_at_stop = cur_x_ff == stop_x_ff;
      y_at_stop = cur_y_ff == stop_y_ff;
   end

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      stop_x_in     = stop_x_ff;
      stop_y_in     = stop_y_ff;
      delta_x_in    = delta_x_ff;
      delta_y_in    = delta_y_ff;
      step_error_in = step_error_ff;
      octant_in     = octant_ff;
      color_in      = color_ff;
      active_in     = active_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      fin           = 1'b1;

      case (octant_ff)
         OCT_VERT: begin
            fin = y_at_stop;
            if (!fin) cur_y_in = cur_y_ff + 1'b1;
         end
         OCT_HORIZ: begin
            fin = x_at_stop;
            if (!fin) cur_x_in = cur_x_ff + 1'b1;
         end
         OCT_SHALLOW_UP: begin
            step_error_in = ERR_BITS'(err_add_dy);
            if (twice_add_dy >= dx_2w) begin
               cur_y_in      = cur_y_ff + 1'b1;
               step_error_in = ERR_BITS'(err_add_dy - dx_w);
            end
            fin = x_at_stop;
            if (!fin) cur_x_in = cur_x_ff + 1'b1;
         end
         OCT_STEEP_UP: begin
            step_error_in = ERR_BITS'(err_add_dx);
            if (twice_add_dx >= dy_2w) begin
               cur_x_in      = cur_x_ff + 1'b1;
               step_error_in = ERR_BITS'(err_add_dx - dy_w);
            end
            fin = y_at_stop;
            if (!fin) cur_y_in = cur_y_ff + 1'b1;
         end
         OCT_SHALLOW_DOWN: begin
            step_error_in = ERR_BITS'(err_sub_dy);
            if (twice_sub_dy <= -dx_2w) begin
               cur_y_in      = cur_y_ff - 1'b1;
               step_error_in = ERR_BITS'(err_sub_dy + dx_w);
            end
            fin = x_at_stop;
            if (!fin) cur_x_in = cur_x_ff + 1'b1;
         end
         OCT_STEEP_DOWN: begin
            step_error_in = ERR_BITS'(err_sub_dx);
            if (twice_sub_dx <= -dy_2w) begin
               cur_x_in      = cur_x_ff + 1'b1;
               step_error_in = ERR_BITS'(err_sub_dx + dy_w);
            end
            fin = y_at_stop;
            if (!fin) cur_y_in = cur_y_ff - 1'b1;
         end
         default: begin
            fin = 1'b1;
         end
      endcase

      if (accept && req_data.kind == KIND_LOAD) begin
         cur_x_in      = first_x;
         cur_y_in      = first_y;
         stop_x_in     = second_x;
         stop_y_in     = second_y;
         delta_x_in    = ld_dx;
         delta_y_in    = ld_dy_abs;
         step_error_in = '0;
         octant_in     = ld_octant;
         color_in      = req_data.pixel_color;
         active_in     = 1'b1;
      end else if (accept && req_data.kind == KIND_STEP && active_ff) begin
         rsp_in.pixel_x   = cur_x_ff;
         rsp_in.pixel_y   = cur_y_ff;
         rsp_in.color_out = color_ff;
         rsp_in.on_screen = !cur_x_ff[COORD_BITS-1] && !cur_y_ff[COORD_BITS-1]
                            && ($unsigned(cur_x_ff) < COORD_BITS'(SCREEN_W))
                            && ($unsigned(cur_y_ff) < COORD_BITS'(SCREEN_H));
         rsp_in.last      = fin;
         rsp_valid_in     = 1'b1;
         active_in        = !fin;
      end else begin
         // hold line state
         cur_x_in      = cur_x_ff;
         cur_y_in      = cur_y_ff;
         step_error_in = step_error_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      stop_x_ff     <= stop_x_in;
      stop_y_ff     <= stop_y_in;
      delta_x_ff    <= delta_x_in;
      delta_y_ff    <= delta_y_in;
      step_error_ff <= step_error_in;
      octant_ff     <= octant_in;
      color_ff      <= color_in;
      rsp_ff        <= rsp_in;
   end

endmodule

// File: dv/tb_line_rasterizer.sv
// Self-checking testbench for line_rasterizer: random and directed line loads and pixel steps.
// Predicts every pixel beat in-line and checks rsp beats in order; needs lnr_pkg and the RTL.
module tb_line_rasterizer;
   import lnr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 500;
   localparam int TAIL_CYCLES  = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   line_rasterizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   req_type cmd_q[$];
   rsp_type pixel_q[$];

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  send_pause    = 1'b0;
   bit  req_fire      = 1'b0;
   int  hold_seq      = 0;
   int  hold_seen     = 0;
   int  hold_left     = 0;
   int  cycle_count   = 0;
   int  error_count   = 0;
   int  load_count    = 0;
   int  pixel_count   = 0;
   int  offscreen_count = 0;
   int  idle_step_count = 0;

   // line state of the predictor
   logic signed [COORD_BITS-1:0] pos_x     = '0;
   logic signed [COORD_BITS-1:0] pos_y     = '0;
   logic signed [COORD_BITS-1:0] stop_px   = '0;
   logic signed [COORD_BITS-1:0] stop_py   = '0;
   logic signed [DELTA_BITS-1:0] run_x     = '0;
   logic signed [DELTA_BITS-1:0] run_y     = '0;
   logic signed [ERR_BITS-1:0]   err_acc   = '0;
   octant_type                   line_oct  = OCT_VERT;
   logic [COLOR_BITS-1:0]        line_col  = '0;
   logic                         drawing   = 1'b0;

   function automatic void rasterize_beat(input req_type r);
      int      x1, y1, x2, y2, t, e, dx, dy;
      logic    fin;
      rsp_type p;
      if (r.kind == KIND_LOAD) begin
         x1 = int'($signed(r.start_x));
         y1 = int'($signed(r.start_y));
         x2 = int'($signed(r.end_x));
         y2 = int'($signed(r.end_y));
         dx = 0;
         dy = 0;
         line_col = r.pixel_color;
         err_acc  = '0;
         drawing  = 1'b1;
         load_count++;
         if (x1 == x2) begin
            if (y1 > y2) begin
               t = y1; y1 = y2; y2 = t;
            end
            line_oct = OCT_VERT;
         end else if (y1 == y2) begin
            if (x1 > x2) begin
               t = x1; x1 = x2; x2 = t;
            end
            line_oct = OCT_HORIZ;
         end else begin
            if (x1 > x2) begin
               t = x1; x1 = x2; x2 = t;
               t = y1; y1 = y2; y2 = t;
            end
            dx = x2 - x1;
            dy = y2 - y1;
            if (dy > 0) begin
               line_oct = (dy < dx) ? OCT_SHALLOW_UP : OCT_STEEP_UP;
            end else begin
               dy = -dy;
               line_oct = (dy < dx) ? OCT_SHALLOW_DOWN : OCT_STEEP_DOWN;
            end
         end
         if (line_oct == OCT_VERT || line_oct == OCT_HORIZ) begin
            dx = x2 - x1;
            dy = y2 - y1;
         end
         run_x   = DELTA_BITS'(dx);
         run_y   = DELTA_BITS'(dy);
         pos_x   = COORD_BITS'(x1);
         pos_y   = COORD_BITS'(y1);
         stop_px = COORD_BITS'(x2);
         stop_py = COORD_BITS'(y2);
      end else if (!drawing) begin
         idle_step_count++;
      end else begin
         x1 = int'(pos_x);
         y1 = int'(pos_y);
         e  = int'(err_acc);
         dx = int'(run_x);
         dy = int'(run_y);
         p.pixel_x   = pos_x;
         p.pixel_y   = pos_y;
         p.color_out = line_col;
         p.on_screen = (x1 >= 0 && x1 < SCREEN_W && y1 >= 0 && y1 < SCREEN_H);
         case (line_oct)
            OCT_VERT: begin
               fin = (pos_y == stop_py);
               if (!fin) pos_y = pos_y + 2'sd1;
            end
            OCT_HORIZ: begin
               fin = (pos_x == stop_px);
               if (!fin) pos_x = pos_x + 2'sd1;
            end
            OCT_SHALLOW_UP: begin
               e += dy;
               if (2 * e >= dx) begin
                  pos_y = pos_y + 2'sd1;
                  e -= dx;
               end
               fin = (pos_x == stop_px);
               if (!fin) pos_x = pos_x + 2'sd1;
            end
            OCT_STEEP_UP: begin
               e += dx;
               if (2 * e >= dy) begin
                  pos_x = pos_x + 2'sd1;
                  e -= dy;
               end
               fin = (pos_y == stop_py);
               if (!fin) pos_y = pos_y + 2'sd1;
            end
            OCT_SHALLOW_DOWN: begin
               e -= dy;
               if (2 * e <= -dx) begin
                  pos_y = pos_y - 2'sd1;
                  e += dx;
               end
               fin = (pos_x == stop_px);
               if (!fin) pos_x = pos_x + 2'sd1;
            end
            OCT_STEEP_DOWN: begin
               e -= dx;
               if (2 * e <= -dy) begin
                  pos_x = pos_x + 2'sd1;
                  e += dy;
               end
               fin = (pos_y == stop_py);
               if (!fin) pos_y = pos_y - 2'sd1;
            end
            default: begin
               fin = 1'b1;
            end
         endcase
         err_acc = ERR_BITS'(e);
         p.last  = fin;
         if (fin) drawing = 1'b0;
         pixel_q.push_back(p);
      end
   endfunction

   function automatic void queue_steps(input int n);
      req_type r;
      repeat (n) begin
         r.kind        = KIND_STEP;
         r.start_x     = COORD_BITS'($urandom);
         r.start_y     = COORD_BITS'($urandom);
         r.end_x       = COORD_BITS'($urandom);
         r.end_y       = COORD_BITS'($urandom);
         r.pixel_color = COLOR_BITS'($urandom);
         cmd_q.push_back(r);
      end
   endfunction

   function automatic void queue_line(input int x1, input int y1, input int x2, input int y2,
                                      input logic [COLOR_BITS-1:0] col, input int nstep);
      req_type r;
      r.kind        = KIND_LOAD;
      r.start_x     = COORD_BITS'(x1);
      r.start_y     = COORD_BITS'(y1);
      r.end_x       = COORD_BITS'(x2);
      r.end_y       = COORD_BITS'(y2);
      r.pixel_color = col;
      cmd_q.push_back(r);
      queue_steps(nstep);
   endfunction

   function automatic int any_coord();
      logic signed [COORD_BITS-1:0] c;
      c = COORD_BITS'($urandom);
      return c;
   endfunction

   // returns the number of beats that do real work
   function automatic int queue_random_line();
      int sel, pick, span, x1, y1, x2, y2, ax, ay, len, nstep;
      sel = $urandom_range(99);
      if (sel < 12) begin
         nstep = $urandom_range(8, 1);
         queue_line(any_coord(), any_coord(), any_coord(), any_coord(),
                    COLOR_BITS'($urandom), nstep);
         return 1 + nstep;
      end
      span = (sel < 20) ? 150 : 12;
      x1 = int'($urandom_range(SCREEN_W + 40)) - 20;
      y1 = int'($urandom_range(SCREEN_H + 40)) - 20;
      x2 = x1 + int'($urandom_range(2 * span)) - span;
      y2 = y1 + int'($urandom_range(2 * span)) - span;
      pick = $urandom_range(9);
      if (pick == 0) x2 = x1;
      else if (pick == 1) y2 = y1;
      ax  = (x2 > x1) ? x2 - x1 : x1 - x2;
      ay  = (y2 > y1) ? y2 - y1 : y1 - y2;
      len = ((ax > ay) ? ax : ay) + 1;
      pick = $urandom_range(9);
      if (pick == 0) nstep = len + int'($urandom_range(3, 1));
      else if (pick == 1) nstep = $urandom_range(len - 1, 0);
      else nstep = len;
      queue_line(x1, y1, x2, y2, COLOR_BITS'($urandom), nstep);
      return 1 + ((nstep < len) ? nstep : len);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (cmd_q.size() > 0 && !send_pause && int'($urandom_range(99)) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= cmd_q[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      req_fire = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_fire = 1'b1;
            rasterize_beat(req_data);
            void'(cmd_q.pop_front());
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               $error("unexpected pixel beat: x=%0d y=%0d", rsp_data.pixel_x, rsp_data.pixel_y);
               error_count++;
            end else begin
               want = pixel_q.pop_front();
               pixel_count++;
               if (!want.on_screen) offscreen_count++;
               if (rsp_data.pixel_x !== want.pixel_x) begin
                  $error("pixel_x: expected %0d, got %0d", want.pixel_x, rsp_data.pixel_x);
                  error_count++;
               end
               if (rsp_data.pixel_y !== want.pixel_y) begin
                  $error("pixel_y: expected %0d, got %0d", want.pixel_y, rsp_data.pixel_y);
                  error_count++;
               end
               if (rsp_data.color_out !== want.color_out) begin
                  $error("color_out: expected %h, got %h", want.color_out, rsp_data.color_out);
                  error_count++;
               end
               if (rsp_data.on_screen !== want.on_screen) begin
                  $error("on_screen: expected %b, got %b", want.on_screen, rsp_data.on_screen);
                  error_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_data.last);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int made;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_steps(1);
      queue_line(0, 0, 0, 0, 16'h0000, 2);
      queue_line(239, 320, 239, 318, 16'h1234, 3);
      queue_line(240, 0, 239, 0, 16'hABCD, 2);
      queue_line(-1, 0, 1, 1, 16'h5555, 3);
      queue_line(0, 0, 1, 1, 16'hAAAA, 2);
      queue_line(0, 1, 2, 0, 16'h0F0F, 3);
      queue_line(1, 0, 0, 1, 16'hF0F0, 2);
      queue_line(-2048, 2047, 2047, -2048, 16'hFFFF, 1);
      queue_line(-2048, -2048, 2047, 2047, 16'h8001, 1);
      queue_line(2047, -2048, -2048, -2048, 16'h7FFE, 1);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 78 : (ph == 3) ? 18 : 0;
         rsp_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 18 : 0;
         made = 0;
         while (made < PHASE_ITEMS) made += queue_random_line();
         if (ph == 0) hold_seq++;
         while (cmd_q.size() != 0 || req_valid) @(posedge clock);
         // hold the sender until every pixel is back
         send_pause = 1'b1;
         while (pixel_q.size() != 0) @(posedge clock);
         send_pause = 1'b0;
      end

      rsp_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d line loads and %0d checked pixels (%0d off screen), %0d idle steps,",
               load_count, pixel_count, offscreen_count, idle_step_count);
      $display("over four traffic mixes with a %0d-cycle output hold-off.", HOLD_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/lnr_pkg.sv
rtl/line_rasterizer.sv
dv/tb_line_rasterizer.sv
